/* rtl/fbm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared constants and types for the fractal value noise pipeline.
// ----------------------------------------------------------------------------
package fbm_pkg;

    localparam int MAX_OCTAVES     = 8;
    localparam int COORD_FRAC_BITS = 16;

    localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
    localparam int SUM_W  = 32 + $clog2(MAX_OCTAVES);
    localparam int WSUM_W = 17 + $clog2(MAX_OCTAVES);
    localparam int QUO_W  = 16;
    localparam int CFG_DW = 32;
    localparam int CFG_AW = 2;

    localparam logic [31:0] HASH_X    = 32'd374761393;
    localparam logic [31:0] HASH_Y    = 32'd668265263;
    localparam logic [31:0] HASH_XY   = HASH_X + HASH_Y;
    localparam logic [31:0] HASH_MIX  = 32'd12741261;
    localparam logic [31:0] SEED_STEP = 32'd100;

    localparam logic [CFG_AW-1:0] REG_OCTAVE_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] REG_LACUNARITY   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_PERSISTENCE  = 2'd2;
    localparam logic [CFG_AW-1:0] REG_NOISE_SEED   = 2'd3;

    typedef struct packed {
        logic                     valid;
        logic signed [31:0]       x;
        logic signed [31:0]       y;
        logic [31:0]              freq;
        logic [16:0]              amp;
        logic [SUM_W-1:0]         sum;
        logic [WSUM_W-1:0]        wsum;
    } t_oct_bus;

endpackage
`default_nettype wire

/* rtl/fbm_octave.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbm_octave
// One noise octave: scale, lattice hash, bilinear blend, weighted accumulate.
// ----------------------------------------------------------------------------
module fbm_octave import fbm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [OCT_W-1:0]  i_index,
    input  wire logic [OCT_W-1:0]  i_count,
    input  wire logic [15:0]       i_lacunarity,
    input  wire logic [15:0]       i_persistence,
    input  wire logic [31:0]       i_seed,
    input  wire t_oct_bus          i_bus,
    output t_oct_bus               o_bus,
    output logic                   o_valid
);

    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] t);
        logic signed [17:0] d;
        logic signed [35:0] p;
        logic signed [35:0] r;
        d = $signed({2'b00, b}) - $signed({2'b00, a});
        p = 36'(d * $signed({1'b0, t}));
        r = 36'($signed({20'd0, a})) + ((p + 36'sd32768) >>> 16);
        return r[15:0];
    endfunction

    function automatic logic [15:0] corner(input logic [31:0] h);
        logic [7:0]  g;
        logic [15:0] m;
        g = h[7:0] ^ h[20:13];
        m = g * HASH_MIX[7:0];
        return {m[7:0], m[7:0]};
    endfunction

    logic [6:0] r_v;

    // stage 1
    t_oct_bus            r1_bus;
    logic signed [71:0]  r1_px, r1_py;
    logic [47:0]         r1_fl;
    logic [32:0]         r1_pa;
    logic signed [64:0]  n_px, n_py;

    assign n_px = i_bus.x * $signed({1'b0, i_bus.freq});
    assign n_py = i_bus.y * $signed({1'b0, i_bus.freq});

    // stage 2
    t_oct_bus    r2_nbus;
    t_oct_bus    n_r2_nbus;
    logic [16:0] r2_amp;
    logic [31:0] r2_cxa, r2_cyb;
    logic [15:0] r2_fx, r2_fy;
    logic [31:0] n_cx, n_cy;
    logic [COORD_FRAC_BITS-1:0] n_frx, n_fry;
    logic [47:0] n_fxw, n_fyw;
    logic [35:0] n_fnx;

    assign n_cx  = r1_px[12+COORD_FRAC_BITS +: 32];
    assign n_cy  = r1_py[12+COORD_FRAC_BITS +: 32];
    assign n_frx = r1_px[12 +: COORD_FRAC_BITS];
    assign n_fry = r1_py[12 +: COORD_FRAC_BITS];
    assign n_fxw = (48'(n_frx) << 16) >> COORD_FRAC_BITS;
    assign n_fyw = (48'(n_fry) << 16) >> COORD_FRAC_BITS;
    assign n_fnx = r1_fl[47:12];

    always_comb begin
        n_r2_nbus      = r1_bus;
        n_r2_nbus.freq = (n_fnx[35:32] != 4'd0) ? 32'hFFFF_FFFF : n_fnx[31:0];
        n_r2_nbus.amp  = r1_pa[32:16];
    end

    // stages 3 to 6
    t_oct_bus    r3_nbus, r4_nbus, r5_nbus, r6_nbus;
    t_oct_bus    n_o_bus;
    logic [16:0] r3_amp, r4_amp, r5_amp, r6_amp;
    logic [31:0] r3_base;
    logic [15:0] r3_fx, r3_fy, r4_fx, r4_fy, r5_fy;
    logic [15:0] r4_v00, r4_v10, r4_v01, r4_v11;
    logic [15:0] r5_r0, r5_r1, r6_n;
    logic        active;
    logic [32:0] n_wt;

    assign active = (i_index < i_count);
    assign n_wt   = r6_n * r6_amp;

    always_comb begin
        n_o_bus = r6_nbus;
        if (active) begin
            n_o_bus.sum  = r6_nbus.sum + SUM_W'(n_wt);
            n_o_bus.wsum = r6_nbus.wsum + WSUM_W'(r6_amp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_bus.valid};
        end
    end

    assign o_valid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bus <= i_bus;
            r1_px  <= 72'(n_px);
            r1_py  <= 72'(n_py);
            r1_fl  <= i_bus.freq * i_lacunarity;
            r1_pa  <= i_bus.amp * i_persistence;

            r2_nbus <= n_r2_nbus;
            r2_amp  <= r1_bus.amp;
            r2_cxa  <= n_cx * HASH_X;
            r2_cyb  <= n_cy * HASH_Y;
            r2_fx   <= n_fxw[15:0];
            r2_fy   <= n_fyw[15:0];

            r3_nbus <= r2_nbus;
            r3_amp  <= r2_amp;
            r3_base <= r2_cxa + r2_cyb + i_seed;
            r3_fx   <= r2_fx;
            r3_fy   <= r2_fy;

            r4_nbus <= r3_nbus;
            r4_amp  <= r3_amp;
            r4_fx   <= r3_fx;
            r4_fy   <= r3_fy;
            r4_v00  <= corner(r3_base);
            r4_v10  <= corner(r3_base + HASH_X);
            r4_v01  <= corner(r3_base + HASH_Y);
            r4_v11  <= corner(r3_base + HASH_XY);

            r5_nbus <= r4_nbus;
            r5_amp  <= r4_amp;
            r5_fy   <= r4_fy;
            r5_r0   <= lerp16(r4_v00, r4_v10, r4_fx);
            r5_r1   <= lerp16(r4_v01, r4_v11, r4_fx);

            r6_nbus <= r5_nbus;
            r6_amp  <= r5_amp;
            r6_n    <= lerp16(r5_r0, r5_r1, r5_fy);

            o_bus <= n_o_bus;
        end
    end

endmodule
`default_nettype wire

/* rtl/fbm_value_noise_2d.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fbm_value_noise_2d
// Fractal value noise: octave pipelines feeding a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Takes one transaction every clock unless stalled. Data passes through
// MAX_OCTAVES octave stages (unused octaves pass through with no weight),
// then 16 divider stages and the output register. The whole pipeline moves
// together: when the output is stalled the input is stalled too.
module fbm_value_noise_2d import fbm_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_AW-1:0]  i_cfg_index,
    input  wire logic [CFG_DW-1:0]  i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_x_coord,
    input  wire logic signed [31:0] i_y_coord,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [15:0]             o_height
);

    logic [3:0]  r_octave_count;
    logic [15:0] r_lacunarity;
    logic [15:0] r_persistence;
    logic [31:0] r_noise_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= 4'd4;
            r_lacunarity   <= 16'd8192;
            r_persistence  <= 16'd32768;
            r_noise_seed   <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[3:0];
                REG_LACUNARITY:   r_lacunarity   <= i_cfg_data[15:0];
                REG_PERSISTENCE:  r_persistence  <= i_cfg_data[15:0];
                REG_NOISE_SEED:   r_noise_seed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [OCT_W-1:0] count;
    always_comb begin
        if (r_octave_count == 4'd0) begin
            count = OCT_W'(1);
        end else if (32'(r_octave_count) > 32'(MAX_OCTAVES)) begin
            count = OCT_W'(MAX_OCTAVES);
        end else begin
            count = OCT_W'(r_octave_count);
        end
    end

    logic     adv;
    logic     r_out_valid;
    logic [15:0] r_out_height;

    assign adv      = !r_out_valid || !i_stall;
    assign o_stall  = !adv;
    assign o_valid  = r_out_valid;
    assign o_height = r_out_height;

    t_oct_bus bus [MAX_OCTAVES+1];

    always_comb begin
        bus[0].valid = i_valid;
        bus[0].x     = i_x_coord;
        bus[0].y     = i_y_coord;
        bus[0].freq  = 32'd4096;
        bus[0].amp   = 17'h10000;
        bus[0].sum   = '0;
        bus[0].wsum  = '0;
    end

    // octave bus valid bits are carried separately with reset
    logic [MAX_OCTAVES:0] oct_v;
    assign oct_v[0] = i_valid;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        t_oct_bus in_bus;
        always_comb begin
            in_bus       = bus[g];
            in_bus.valid = oct_v[g];
        end
        fbm_octave u_oct (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (adv),
            .i_index       (OCT_W'(g)),
            .i_count       (count),
            .i_lacunarity  (r_lacunarity),
            .i_persistence (r_persistence),
            .i_seed        (r_noise_seed + 32'(SEED_STEP * 32'(g))),
            .i_bus         (in_bus),
            .o_bus         (bus[g+1]),
            .o_valid       (oct_v[g+1])
        );
    end

    // restoring division, one quotient bit per stage
    logic               r_dv_v   [QUO_W];
    logic [SUM_W:0]     r_dv_rem [QUO_W];
    logic [QUO_W-1:0]   r_dv_q   [QUO_W];
    logic [WSUM_W-1:0]  r_dv_w   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [SUM_W:0]    rem_in;
        logic [QUO_W-1:0]  q_in;
        logic [WSUM_W-1:0] w_in;
        logic              v_in;
        logic [SUM_W:0]    shw;
        if (k == 0) begin : g_first
            assign rem_in = (SUM_W+1)'(bus[MAX_OCTAVES].sum)
                          + (SUM_W+1)'(bus[MAX_OCTAVES].wsum >> 1);
            assign q_in   = '0;
            assign w_in   = bus[MAX_OCTAVES].wsum;
            assign v_in   = oct_v[MAX_OCTAVES];
        end else begin : g_next
            assign rem_in = r_dv_rem[k-1];
            assign q_in   = r_dv_q[k-1];
            assign w_in   = r_dv_w[k-1];
            assign v_in   = r_dv_v[k-1];
        end
        assign shw = (SUM_W+1)'(w_in) << (QUO_W - 1 - k);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (adv) begin
                r_dv_v[k] <= v_in;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_w[k] <= w_in;
                if (rem_in >= shw) begin
                    r_dv_rem[k] <= rem_in - shw;
                    r_dv_q[k]   <= q_in | (QUO_W'(1) << (QUO_W - 1 - k));
                end else begin
                    r_dv_rem[k] <= rem_in;
                    r_dv_q[k]   <= q_in;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_dv_v[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_height <= r_dv_q[QUO_W-1];
        end
    end

endmodule
`default_nettype wire

/* tb/sv/fbm_value_noise_2d_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbm_value_noise_2d_test
// Drives sample points through the fractal noise pipeline under several
// register settings and idle/stall mixes, predicts each height in fixed point
// and checks the results in order.
// ----------------------------------------------------------------------------
module fbm_value_noise_2d_test import fbm_pkg::*;;

    class height_scoreboard;
        logic [3:0]  octaves;
        logic [15:0] lacunarity;
        logic [15:0] persistence;
        logic [31:0] seed;
        logic [15:0] pending[$];
        int          errors;

        function new();
            octaves = 4'd4; lacunarity = 16'd8192; persistence = 16'd32768; seed = '0;
            errors = 0;
        endfunction

        function logic [15:0] corner(logic [31:0] cx, logic [31:0] cy, logic [31:0] s);
            logic [31:0] h;
            h = cx * HASH_X + cy * HASH_Y + s;
            h = (h ^ (h >> 13)) * HASH_MIX;
            return h[7:0] * 16'd257;
        endfunction

        function logic [15:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] t);
            logic [63:0] r;
            r = 64'(a) * (64'd65536 - 64'(t)) + 64'(b) * 64'(t) + 64'd32768;
            return r[31:16];
        endfunction

        function void split(logic [31:0] c, logic [63:0] freq,
                            output logic [31:0] lat, output logic [31:0] frac);
            logic signed [63:0] p;
            logic signed [63:0] sc;
            p = $signed({{32{c[31]}}, c}) * $signed(freq);
            sc = p >>> 12;
            lat = 32'(sc >>> COORD_FRAC_BITS);
            frac = {16'd0, sc[15:0]};
        endfunction

        function void note_point(logic [31:0] x, logic [31:0] y);
            int          n;
            logic [63:0] freq, amp, sum, wsum, q;
            logic [31:0] cx, cy, fx, fy, s;
            logic [15:0] r0, r1, v;
            n = (octaves < 1) ? 1 : (octaves > MAX_OCTAVES ? MAX_OCTAVES : octaves);
            freq = 4096; amp = 65536; sum = 0; wsum = 0;
            for (int i = 0; i < n; i++) begin
                split(x, freq, cx, fx);
                split(y, freq, cy, fy);
                s = seed + SEED_STEP * i;
                r0 = blend(corner(cx, cy, s), corner(cx + 1, cy, s), fx);
                r1 = blend(corner(cx, cy + 1, s), corner(cx + 1, cy + 1, s), fx);
                v = blend(r0, r1, fy);
                sum += 64'(v) * amp;
                wsum += amp;
                freq = (freq * lacunarity) >> 12;
                if (freq > 64'hFFFFFFFF) freq = 64'hFFFFFFFF;
                amp = (amp * persistence) >> 16;
            end
            q = (sum + wsum / 2) / wsum;
            pending.push_back(q > 65535 ? 16'hFFFF : q[15:0]);
        endfunction

        function void check_height(logic [15:0] got);
            logic [15:0] want;
            if (pending.size() == 0) begin
                $error("height: unexpected transaction, actual %0d", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $error("height: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [CFG_AW-1:0]  i_cfg_index = '0;
    logic [CFG_DW-1:0]  i_cfg_data = '0;
    logic               i_valid = 0;
    logic               o_stall;
    logic signed [31:0] i_x_coord = 0;
    logic signed [31:0] i_y_coord = 0;
    logic               o_valid;
    logic               i_stall = 0;
    logic [15:0]        o_height;

    height_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  quiet_cycles = 0;
    bit  done = 0;

    localparam int PIPE_LATENCY = 7 * MAX_OCTAVES + 20;
    localparam int QUIET_LIMIT  = 200000;

    fbm_value_noise_2d DUT (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_height(o_height);
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT && !done) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_OCTAVE_COUNT: sb.octaves = val[3:0];
            REG_LACUNARITY:   sb.lacunarity = val[15:0];
            REG_PERSISTENCE:  sb.persistence = val[15:0];
            REG_NOISE_SEED:   sb.seed = val;
            default: ;
        endcase
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_x_coord <= x; i_y_coord <= y;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(x, y);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY) @(negedge i_clk);
    endtask

    task automatic configure(int oc, int lac, int per, logic [31:0] sd);
        drain();
        write_reg(REG_OCTAVE_COUNT, oc);
        write_reg(REG_LACUNARITY, lac);
        write_reg(REG_PERSISTENCE, per);
        write_reg(REG_NOISE_SEED, sd);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
        endcase
    endfunction

    task automatic random_points(int count);
        for (int k = 0; k < count; k++) begin
            send_point(rand_coord(), rand_coord());
            if (k == count / 2 && count > 100) begin
                i_valid <= 0;
                while (sb.pending.size() != 0) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;

        // directed extremes, first at reset settings, then at edge register settings
        send_point(32'h0, 32'h0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000);
        send_point(32'hFFFFFFFF, 32'h00000001);
        send_point(32'h0000FFFF, 32'hFFFF0000);
        send_point(32'h00018000, 32'hFFFE8000);
        configure(0, 0, 0, 32'hFFFFFFFF);
        send_point(32'h12345678, 32'h87654321);
        send_point(32'h7FFFFFFF, 32'h80000000);
        configure(15, 65535, 65535, 32'h0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h00008000);
        send_point(32'hFFFFFFFF, 32'hFFFFFFFF);
        configure(8, 0, 65535, 32'h5A5A5A5A);
        send_point(32'h00054321, 32'hFFFAB000);
        configure(3, 16384, 0, 32'hA5A5A5A5);
        send_point(32'h00054321, 32'hFFFAB000);

        // randomised phases, mixing idle and stall patterns
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 0) configure(4, 8192, 32768, 0);
            else if (ph == 7) configure(8, 65535, 65535, 32'hFFFFFFFF);
            else configure($urandom_range(15), $urandom_range(65535),
                           $urandom_range(65535), $urandom);
            random_points(220);
        end

        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            drain();
            begin
                repeat (QUIET_LIMIT) @(negedge i_clk);
            end
        join_any
        done = 1;
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
